// ===== rtl/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the BCD clock and calendar
// Holds the operation codes, the packed calendar word that matches the
// stream data layout, and the reset values of the clock state.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // Operation carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_UPDATE     = 2'd0,
    OP_LOAD       = 2'd1,
    OP_RESET_DATE = 2'd2,
    OP_RESET_TIME = 2'd3
  } op_t;

  // Calendar word. The last member sits in the lowest bits, so the layout is
  // identical to the tdata packing of both stream channels (40 bits).
  typedef struct packed {
    logic [3:0] year_units;
    logic [3:0] year_tens;
    logic [3:0] month_units;
    logic       month_tens;
    logic [3:0] day_units;
    logic [1:0] day_tens;
    logic [3:0] minute_units;
    logic [2:0] minute_tens;
    logic [3:0] hour_units;
    logic [1:0] hour_tens;
    logic [7:0] seconds;
  } cal_word_t;

  localparam int unsigned DATA_W = $bits(cal_word_t);

  // Highest seconds value that does not advance the minute.
  localparam logic [7:0] SECONDS_MAX = 8'd59;

  // State after reset: 00:00 on 01/01/00 with the seconds count cleared.
  localparam cal_word_t CAL_RESET = '{
    year_units:   4'd0,
    year_tens:    4'd0,
    month_units:  4'd1,
    month_tens:   1'b0,
    day_units:    4'd1,
    day_tens:     2'd0,
    minute_units: 4'd0,
    minute_tens:  3'd0,
    hour_units:   4'd0,
    hour_tens:    2'd0,
    seconds:      8'd0
  };

endpackage

// ===== rtl/bcc_advance.sv =====
// ----------------------------------------------------------------------------
// bcc_advance: one-minute advance of the BCD clock and calendar
// Ripples a carry from the minute units through hour, day, month and year.
// Every month has 31 days; year 99 wraps to 00. Out-of-range digits are
// compared against the same limits and wrap within their own width.
// ----------------------------------------------------------------------------
module bcc_advance (
  input  bcc_pkg::cal_word_t cur_i,
  output bcc_pkg::cal_word_t nxt_o
);

  // Working digits carry one extra bit so that an increment never wraps
  // before it is compared.
  logic [4:0] mu;
  logic [3:0] mt;
  logic [4:0] hu;
  logic [2:0] ht;
  logic [4:0] du;
  logic [2:0] dt;
  logic [4:0] nu;
  logic [1:0] nt;
  logic [4:0] yu;
  logic [4:0] yt;

  // Carry chain, minute units first.
  always_comb begin
    mu = {1'b0, cur_i.minute_units};
    mt = {1'b0, cur_i.minute_tens};
    hu = {1'b0, cur_i.hour_units};
    ht = {1'b0, cur_i.hour_tens};
    du = {1'b0, cur_i.day_units};
    dt = {1'b0, cur_i.day_tens};
    nu = {1'b0, cur_i.month_units};
    nt = {1'b0, cur_i.month_tens};
    yu = {1'b0, cur_i.year_units};
    yt = {1'b0, cur_i.year_tens};

    mu = mu + 5'd1;
    if (mu > 5'd9) begin
      mu = '0;
      mt = mt + 4'd1;
      if (mt > 4'd5) begin
        mt = '0;
        hu = hu + 5'd1;
        if (hu > 5'd9 && ht < 3'd2) begin
          hu = '0;
          ht = ht + 3'd1;
        end
        // Midnight: 23:59 rolls over to 00:00 and the day advances.
        if (hu > 5'd3 && ht == 3'd2) begin
          hu = '0;
          ht = '0;
          du = du + 5'd1;
          if (du > 5'd9 && dt < 3'd4) begin
            du = '0;
            dt = dt + 3'd1;
          end
          // End of month after day 31.
          if (du > 5'd1 && dt == 3'd3) begin
            du = 5'd1;
            dt = '0;
            nu = nu + 5'd1;
            if (nu > 5'd9 && nt < 2'd1) begin
              nu = '0;
              nt = nt + 2'd1;
            end
            // End of year after month 12.
            if (nu > 5'd2 && nt == 2'd1) begin
              nu = 5'd1;
              nt = '0;
              yu = yu + 5'd1;
              if (yu > 5'd9) begin
                yu = '0;
                yt = yt + 5'd1;
                if (yt > 5'd9) begin
                  yt = '0;
                end
              end
            end
          end
        end
      end
    end
  end

  // Truncate each digit back to its field width.
  always_comb begin
    nxt_o              = cur_i;
    nxt_o.minute_units = mu[3:0];
    nxt_o.minute_tens  = mt[2:0];
    nxt_o.hour_units   = hu[3:0];
    nxt_o.hour_tens    = ht[1:0];
    nxt_o.day_units    = du[3:0];
    nxt_o.day_tens     = dt[1:0];
    nxt_o.month_units  = nu[3:0];
    nxt_o.month_tens   = nt[0];
    nxt_o.year_units   = yu[3:0];
    nxt_o.year_tens    = yt[3:0];
  end

endmodule

// ===== rtl/bcd_clock_calendar.sv =====
// ----------------------------------------------------------------------------
// bcd_clock_calendar: BCD clock and calendar with a streaming interface
// Pipeline: two register stages, the input register and then the state
// register; a transaction waits in the input register while a result stalls.
// Throughput: one transaction per cycle while no result stalls, set by the
// input register and the state register, which doubles as the result
// register. Reset (synchronous, active low) sets 00:00 on 01/01/00 with
// seconds 0 and empties both register stages.
// ----------------------------------------------------------------------------
module bcd_clock_calendar (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // Fields from bit 0: seconds_value, hour_tens, hour_units, minute_tens,
  // minute_units, day_tens, day_units, month_tens, month_units, year_tens,
  // year_units.
  input  logic [bcc_pkg::DATA_W-1:0] in_tdata,
  // Fields from bit 0: operation.
  input  logic [1:0]                 in_tuser,
  // Result channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // Fields from bit 0: out_seconds, out_hour_tens, out_hour_units,
  // out_minute_tens, out_minute_units, out_day_tens, out_day_units,
  // out_month_tens, out_month_units, out_year_tens, out_year_units.
  output logic [bcc_pkg::DATA_W-1:0] out_tdata
);

  logic               s1_valid_r;
  bcc_pkg::op_t       s1_op_r;
  bcc_pkg::cal_word_t s1_word_r;
  logic               s1_adv;

  bcc_pkg::cal_word_t state_r;
  bcc_pkg::cal_word_t state_nxt;
  bcc_pkg::cal_word_t adv_word;
  logic               out_valid_r;

  // Handshake: the input stage moves on whenever the result register is free
  // or is being emptied in the same cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= bcc_pkg::op_t'(in_tuser);
      s1_word_r <= bcc_pkg::cal_word_t'(in_tdata);
    end
  end

  // Minute advance of the current state.
  bcc_advance u_advance (
    .cur_i (state_r),
    .nxt_o (adv_word)
  );

  // Operation select.
  always_comb begin
    state_nxt = state_r;
    unique case (s1_op_r)
      bcc_pkg::OP_UPDATE: begin
        if (s1_word_r.seconds > bcc_pkg::SECONDS_MAX) begin
          state_nxt         = adv_word;
          state_nxt.seconds = '0;
        end else begin
          state_nxt.seconds = s1_word_r.seconds;
        end
      end
      bcc_pkg::OP_LOAD: begin
        state_nxt         = s1_word_r;
        state_nxt.seconds = state_r.seconds;
      end
      bcc_pkg::OP_RESET_DATE: begin
        state_nxt.day_tens    = bcc_pkg::CAL_RESET.day_tens;
        state_nxt.day_units   = bcc_pkg::CAL_RESET.day_units;
        state_nxt.month_tens  = bcc_pkg::CAL_RESET.month_tens;
        state_nxt.month_units = bcc_pkg::CAL_RESET.month_units;
        state_nxt.year_tens   = bcc_pkg::CAL_RESET.year_tens;
        state_nxt.year_units  = bcc_pkg::CAL_RESET.year_units;
      end
      bcc_pkg::OP_RESET_TIME: begin
        state_nxt.hour_tens    = bcc_pkg::CAL_RESET.hour_tens;
        state_nxt.hour_units   = bcc_pkg::CAL_RESET.hour_units;
        state_nxt.minute_tens  = bcc_pkg::CAL_RESET.minute_tens;
        state_nxt.minute_units = bcc_pkg::CAL_RESET.minute_units;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  // Clock state, which is also the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcc_pkg::CAL_RESET;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = state_r;

endmodule

// ===== rtl/bcc_checker.sv =====
// ----------------------------------------------------------------------------
// bcc_checker: port-level checks for the BCD clock and calendar
// Watches the top-level ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
module bcc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [bcc_pkg::DATA_W-1:0] out_tdata
);

  // A stalled result holds its data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With an empty result register the input side is always ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

  // A transaction to an idle block shows a result after both stages.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |-> ##2 out_tvalid)
    else $error("result missing after an input transaction");

  // The stored seconds count never exceeds the rollover limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] <= bcc_pkg::SECONDS_MAX)
    else $error("seconds count above rollover limit");

endmodule

bind bcd_clock_calendar bcc_checker u_bcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
